### design/mpq_pkg.sv
// Shared types and codes for the min priority queue.
// No dependencies; imported by min_priority_queue.
`default_nettype none

package mpq_pkg;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FIX    = 2'd2,
        ST_FINISH = 2'd3
    } mpq_state_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } mpq_op_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    localparam int VALUE_W    = 32;
    localparam int PRIORITY_W = 16;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 4;

endpackage

`default_nettype wire

### design/min_priority_queue.sv
// Top level of the min priority queue: control, entry memories, result register.
// Depends on mpq_pkg for state, opcode and status codes.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid in_ready opcode item_value       | insert or remove transaction
//          | item_priority                             |
//  out     | out_valid out_ready out_value status      | one result per transaction
//          | fill_count                                |
//
// Insert, overflow and underflow go from idle straight to the finish state. A remove
// makes one pass over the single read port of the entry memories to find the
// minimum, then one pass to rewrite the ages. The result register
// lets the next transaction start while a result waits on out_ready.
// Reset empties the queue; entry memories need no clearing.
`default_nettype none

module min_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         opcode,
    input  wire logic signed [VALUE_W-1:0]    item_value,
    input  wire logic [PRIORITY_W-1:0]        item_priority,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [VALUE_W-1:0]         out_value,
    output logic [STATUS_W-1:0]               status,
    output logic [FILL_W-1:0]                 fill_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VP_W  = VALUE_W + PRIORITY_W;

    typedef logic [VP_W-1:0]  vp_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    vp_t  vp_mem  [CAPACITY];
    idx_t age_mem [CAPACITY];

    mpq_state_t state_reg, state_next;
    cnt_t       count_reg;
    cnt_t       rd_idx_reg;
    logic       tag_vld_reg;
    idx_t       tag_idx_reg;
    vp_t        rd_vp_reg;
    idx_t       rd_age_reg;

    logic [PRIORITY_W-1:0]     best_pri_reg;
    logic signed [VALUE_W-1:0] best_value_reg;
    idx_t                      best_age_reg;
    idx_t                      best_idx_reg;
    vp_t                       last_vp_reg;
    idx_t                      last_age_reg;

    logic signed [VALUE_W-1:0] res_value_reg;
    logic [STATUS_W-1:0]       res_status_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [FILL_W-1:0]         fill_count_reg;

    logic      in_fire;
    logic      is_insert;
    logic      full;
    logic      empty;
    idx_t      last_idx;
    logic      rd_issue;
    logic      scan_done;
    logic      fix_done;
    logic      out_load;
    logic      take;
    logic      ins_ok;
    logic [PRIORITY_W-1:0]     rd_pri;
    logic signed [VALUE_W-1:0] rd_value;

    logic      vp_we;
    idx_t      vp_waddr;
    vp_t       vp_wdata;
    logic      age_we;
    idx_t      age_waddr;
    idx_t      age_wdata;
    idx_t      fix_age;

    function automatic idx_t age_adjust(input idx_t age, input idx_t gone);
        idx_t r;
        r = age;
        if (age > gone)
        begin
            r = age - idx_t'(1);
        end
        return r;
    endfunction

    assign in_fire   = in_valid && in_ready;
    assign is_insert = (mpq_op_t'(opcode) == OP_INSERT);
    assign full      = (count_reg == cnt_t'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign last_idx  = idx_t'(count_reg - cnt_t'(1));
    assign ins_ok    = in_fire && is_insert && !full;

    assign rd_pri   = rd_vp_reg[VP_W-1:VALUE_W];
    assign rd_value = rd_vp_reg[VALUE_W-1:0];
    assign take     = (tag_idx_reg == '0) || (rd_pri < best_pri_reg) ||
                      ((rd_pri == best_pri_reg) && (rd_age_reg < best_age_reg));

    assign fix_age = (tag_idx_reg == best_idx_reg) ? age_adjust(last_age_reg, best_age_reg)
                                                   : age_adjust(rd_age_reg, best_age_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!is_insert && !empty)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (fix_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rd_issue  = 1'b0;
        scan_done = 1'b0;
        fix_done  = 1'b0;
        out_load  = 1'b0;
        vp_we     = 1'b0;
        vp_waddr  = idx_t'(count_reg);
        vp_wdata  = {item_priority, item_value};
        age_we    = 1'b0;
        age_waddr = idx_t'(count_reg);
        age_wdata = idx_t'(count_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                vp_we    = ins_ok;
                age_we   = ins_ok;
            end
            ST_SCAN:
            begin
                rd_issue  = (rd_idx_reg < count_reg);
                scan_done = tag_vld_reg && (tag_idx_reg == last_idx);
            end
            ST_FIX:
            begin
                rd_issue  = (rd_idx_reg < count_reg);
                fix_done  = empty || (tag_vld_reg && (tag_idx_reg == last_idx));
                vp_we     = 1'b1;
                vp_waddr  = best_idx_reg;
                vp_wdata  = last_vp_reg;
                age_we    = tag_vld_reg;
                age_waddr = tag_idx_reg;
                age_wdata = fix_age;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (vp_we)
        begin
            vp_mem[vp_waddr] <= vp_wdata;
        end
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        rd_vp_reg  <= vp_mem[idx_t'(rd_idx_reg)];
        rd_age_reg <= age_mem[idx_t'(rd_idx_reg)];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            tag_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ins_ok)
            begin
                count_reg <= count_reg + cnt_t'(1);
            end
            else if (scan_done)
            begin
                count_reg <= count_reg - cnt_t'(1);
            end
            if (in_fire || scan_done)
            begin
                rd_idx_reg  <= '0;
                tag_vld_reg <= 1'b0;
            end
            else
            begin
                tag_vld_reg <= rd_issue;
                if (rd_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + cnt_t'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tag_idx_reg <= idx_t'(rd_idx_reg);
        if (state_reg == ST_SCAN && tag_vld_reg)
        begin
            if (take)
            begin
                best_pri_reg   <= rd_pri;
                best_value_reg <= rd_value;
                best_age_reg   <= rd_age_reg;
                best_idx_reg   <= tag_idx_reg;
            end
            if (tag_idx_reg == last_idx)
            begin
                last_vp_reg  <= rd_vp_reg;
                last_age_reg <= rd_age_reg;
            end
        end
        if (in_fire)
        begin
            res_value_reg <= '0;
            if (is_insert)
            begin
                res_status_reg <= full ? STATUS_OVERFLOW : STATUS_OK;
            end
            else
            begin
                res_status_reg <= empty ? STATUS_UNDERFLOW : STATUS_OK;
            end
        end
        else if (scan_done)
        begin
            res_value_reg <= take ? rd_value : best_value_reg;
        end
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            status_reg     <= res_status_reg;
            fill_count_reg <= FILL_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign status     = status_reg;
    assign fill_count = fill_count_reg;

endmodule

`default_nettype wire
